// ===== rtl/ffsa_pkg.sv =====
// package for the first-fit split allocator: status codes and default sizes
// no dependencies
`default_nettype none
package ffsa_pkg;
    localparam int unsigned DefMaxBlocks   = 64;
    localparam int unsigned DefPageBytes   = 4096;
    localparam int unsigned DefHeaderBytes = 32;
    localparam int unsigned DefHeapBytes   = 1048576;

    localparam int unsigned SizeW = 21;
    localparam int unsigned OffW  = 20;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LIMIT = 2'd1,
        ST_FULL  = 2'd2
    } status_t;
endpackage
`default_nettype wire

// ===== rtl/first_fit_split_allocator.sv =====
// first-fit heap allocator with block splitting, top level
// depends on ffsa_pkg; holds the block table memory and its sequencer
//
// usage
//   s_valid/s_ready carry one request_size per transfer; m_valid/m_ready
//   carry one result (status, payload_offset, granted_size) per request.
//   cfg_valid/cfg_ready write heap_limit; write only while the block is idle.
// operation
//   one request at a time. the scan reads one table entry per cycle from a
//   single-port memory with a registered read. a split shifts the entries
//   after the pick up by one, each entry moved with a read, then a write.
// reset
//   aresetn low clears block count, heap break and control and sets
//   heap_limit to 1048576; the table memory itself is not cleared, only
//   entries below the count are ever used.
// stalls
//   the result sits in an output register until m_ready; a new request is
//   not taken before that result is delivered.
`default_nettype none
module first_fit_split_allocator #(
    parameter int unsigned MAX_BLOCKS   = ffsa_pkg::DefMaxBlocks,
    parameter int unsigned PAGE_BYTES   = ffsa_pkg::DefPageBytes,
    parameter int unsigned HEADER_BYTES = ffsa_pkg::DefHeaderBytes,
    parameter int unsigned HEAP_BYTES   = ffsa_pkg::DefHeapBytes
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [ffsa_pkg::SizeW-1:0]  cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [ffsa_pkg::SizeW-1:0]  s_request_size,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [1:0]                       m_status,
    output logic [ffsa_pkg::OffW-1:0]        m_payload_offset,
    output logic [ffsa_pkg::SizeW-1:0]       m_granted_size
);
    import ffsa_pkg::*;

    localparam int unsigned IdxW  = $clog2(MAX_BLOCKS);
    localparam int unsigned CntW  = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned PageSh = $clog2(PAGE_BYTES);
    // wide arithmetic width, covers break + span and size + header
    localparam int unsigned WW = 26;
    localparam logic [WW-1:0] Hdr = WW'(HEADER_BYTES);
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BLOCKS);
    localparam logic [WW-1:0] HeapB = WW'(HEAP_BYTES);

    typedef struct packed {
        logic [OffW-1:0]  start;
        logic [SizeW-1:0] bytes;
        logic             free;
    } entry_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DEC   = 7'b0000100,
        S_SHRD  = 7'b0001000,
        S_SHWR  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    // block table, single port
    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;
    logic            mem_we;
    logic [IdxW-1:0] mem_addr;
    entry_t          mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    state_t state_reg, state_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic [WW-1:0]    brk_reg, brk_next;
    logic [SizeW-1:0] limit_reg, limit_next;
    logic [SizeW-1:0] req_reg, req_next;
    logic [CntW-1:0]  idx_reg, idx_next;     // scan address / shift pointer
    logic             rdv_reg, rdv_next;     // read in flight for entry idx-1
    logic [IdxW-1:0]  pick_reg, pick_next;
    entry_t           pent_reg, pent_next;   // picked or grown block
    logic             split_reg, split_next;
    logic             mv_reg, mv_next;
    logic [1:0]       st_reg, st_next;
    logic [OffW-1:0]  off_reg, off_next;
    logic [SizeW-1:0] gsz_reg, gsz_next;

    // checked entry index = idx_reg - 1
    logic [CntW-1:0] chk_idx;
    logic            chk_last, chk_fit;
    logic [WW-1:0]   req_w, reqh, span, gsize, lim_w, lim_force;

    always_comb begin
        req_w   = WW'(req_reg);
        reqh    = req_w + Hdr;
        span    = ((reqh >> PageSh) + WW'(1)) << PageSh;
        gsize   = span - Hdr;
        lim_w   = WW'(limit_reg);
        lim_force = (lim_w < HeapB) ? lim_w : HeapB;
        chk_idx = idx_reg - CntW'(1);
        chk_last = (chk_idx == count_reg - CntW'(1));
        if (chk_last) begin
            chk_fit = rd_data_reg.free && (WW'(rd_data_reg.bytes) >= req_w);
        end else begin
            chk_fit = rd_data_reg.free &&
                      ((WW'(rd_data_reg.bytes) > reqh) || (WW'(rd_data_reg.bytes) == req_w));
        end
    end

    assign cfg_ready = (state_reg == S_IDLE) && !mv_reg;
    assign s_ready   = (state_reg == S_IDLE) && !mv_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        brk_next   = brk_reg;
        limit_next = limit_reg;
        req_next   = req_reg;
        idx_next   = idx_reg;
        rdv_next   = 1'b0;
        pick_next  = pick_reg;
        pent_next  = pent_reg;
        split_next = split_reg;
        mv_next    = mv_reg;
        st_next    = st_reg;
        off_next   = off_reg;
        gsz_next   = gsz_reg;
        mem_we     = 1'b0;
        mem_addr   = idx_reg[IdxW-1:0];
        mem_wdata  = pent_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (cfg_valid && cfg_ready) begin
                    limit_next = cfg_data;
                end
                if (s_valid && s_ready) begin
                    req_next   = s_request_size;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue read at idx, check entry idx-1 from last cycle
                if (rdv_reg && chk_fit) begin
                    pick_next  = chk_idx[IdxW-1:0];
                    pent_next  = rd_data_reg;
                    idx_next   = '0;     // clear, so a hit is never taken for a grow
                    state_next = S_DEC;
                end else if (idx_reg >= count_reg) begin
                    // nothing left to read; grow the heap if the limit allows
                    pick_next  = count_reg[IdxW-1:0];
                    pent_next.start = brk_reg[OffW-1:0];
                    pent_next.bytes = gsize[SizeW-1:0];
                    pent_next.free  = 1'b1;
                    if (brk_reg + span > lim_force) begin
                        st_next    = ST_LIMIT;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_DEC;
                        idx_next   = MaxCnt; // marks grow
                    end
                end else begin
                    rdv_next = 1'b1;
                    idx_next = idx_reg + CntW'(1);
                end
            end
            S_DEC: begin
                // idx_reg == MaxCnt flags a grow
                split_next = (WW'(pent_reg.bytes) > reqh);
                if (CntW'(count_reg) + ((idx_reg == MaxCnt) ? CntW'(1) : CntW'(0))
                    + ((WW'(pent_reg.bytes) > reqh) ? CntW'(1) : CntW'(0)) > MaxCnt
                    || (count_reg == MaxCnt && idx_reg == MaxCnt)) begin
                    st_next    = ST_FULL;
                    state_next = S_OUT;
                end else begin
                    if (idx_reg == MaxCnt) begin
                        // append grown block
                        mem_we     = 1'b1;
                        mem_addr   = count_reg[IdxW-1:0];
                        mem_wdata  = pent_reg;
                        count_next = count_reg + CntW'(1);
                        brk_next   = brk_reg + span;
                    end
                    // shift pointer: last occupied index after any append
                    idx_next   = ((idx_reg == MaxCnt) ? count_reg + CntW'(1) : count_reg)
                                 - CntW'(1);
                    state_next = (WW'(pent_reg.bytes) > reqh) ? S_SHRD : S_FIN;
                end
            end
            S_SHRD: begin
                if (idx_reg == CntW'(pick_reg)) begin
                    // insert remainder after the pick
                    mem_we    = 1'b1;
                    mem_addr  = pick_reg + IdxW'(1);
                    mem_wdata.start = OffW'(WW'(pent_reg.start) + reqh);
                    mem_wdata.bytes = SizeW'(WW'(pent_reg.bytes) - reqh);
                    mem_wdata.free  = 1'b1;
                    count_next = count_reg + CntW'(1);
                    state_next = S_FIN;
                end else begin
                    mem_addr   = idx_reg[IdxW-1:0];
                    state_next = S_SHWR;
                end
            end
            S_SHWR: begin
                mem_we     = 1'b1;
                mem_addr   = IdxW'(idx_reg + CntW'(1));
                mem_wdata  = rd_data_reg;
                idx_next   = idx_reg - CntW'(1);
                state_next = S_SHRD;
            end
            S_FIN: begin
                mem_we    = 1'b1;
                mem_addr  = pick_reg;
                mem_wdata.start = pent_reg.start;
                mem_wdata.bytes = split_reg ? req_reg : pent_reg.bytes;
                mem_wdata.free  = 1'b0;
                st_next   = ST_OK;
                off_next  = OffW'(WW'(pent_reg.start) + Hdr);
                gsz_next  = split_reg ? req_reg : pent_reg.bytes;
                mv_next   = 1'b1;
                state_next = S_IDLE;
            end
            S_OUT: begin
                off_next   = '0;
                gsz_next   = '0;
                mv_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            brk_reg   <= '0;
            limit_reg <= SizeW'(1048576);
            rdv_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            brk_reg   <= brk_next;
            limit_reg <= limit_next;
            rdv_reg   <= rdv_next;
            mv_reg    <= mv_next;
        end
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        pick_reg  <= pick_next;
        pent_reg  <= pent_next;
        split_reg <= split_next;
        st_reg    <= st_next;
        off_reg   <= off_next;
        gsz_reg   <= gsz_next;
    end

    assign m_valid          = mv_reg;
    assign m_status         = st_reg;
    assign m_payload_offset = off_reg;
    assign m_granted_size   = gsz_reg;

    // table never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MaxCnt) else $error("block count overflow");
    // heap break never passes the heap size
    a_break_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        brk_reg <= HeapB) else $error("heap break overflow");
    // a failure leaves the count unchanged
    a_fail_nochange: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |=> $stable(count_reg)) else $error("count changed on failure");
    // no request taken while a result waits
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request taken with result pending");
endmodule
`default_nettype wire

// ===== tb/first_fit_split_allocator_test.sv =====
// testbench for first_fit_split_allocator: directed and random requests checked
// against a behavioral first-fit allocator kept in the testbench
// depends on ffsa_pkg and the first_fit_split_allocator rtl
`default_nettype none
module first_fit_split_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ffsa_pkg::*;

    localparam int unsigned NBLK   = DefMaxBlocks;
    localparam longint      PAGE   = DefPageBytes;
    localparam longint      HDR    = DefHeaderBytes;
    localparam longint      HEAPSZ = DefHeapBytes;
    localparam int unsigned DRAIN_CYCLES = 3 * NBLK + 40;

    // one expected result of an allocation
    typedef struct {
        status_t          status;
        logic [OffW-1:0]  offset;
        logic [SizeW-1:0] gsize;
    } alloc_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic [SizeW-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic [SizeW-1:0] s_request_size = '0;
    logic m_ready = 1'b0;
    logic cfg_ready, s_ready, m_valid;
    logic [1:0] m_status;
    logic [OffW-1:0] m_payload_offset;
    logic [SizeW-1:0] m_granted_size;

    // shadow heap: block table, break and limit register
    longint blk_start [NBLK];
    longint blk_bytes [NBLK];
    bit     blk_free  [NBLK];
    int     blk_count = 0;
    longint brk = 0;
    longint limit_reg = 1048576;

    alloc_result_t pending_results[$];
    int  mismatches = 0;
    bit  quiet = 1'b0;     // no idling on either side when set
    int  stall_left = 0;

    first_fit_split_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_request_size(s_request_size),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_payload_offset(m_payload_offset), .m_granted_size(m_granted_size)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // first-fit search, growth by pages, split of the chosen block
    function automatic alloc_result_t allocate(logic [SizeW-1:0] req_bits);
        alloc_result_t r;
        longint req, span, sz, lim;
        int pick, i, need;
        bit found, grow, split;
        req = req_bits;
        r.status = ST_OK;
        r.offset = '0;
        r.gsize = '0;
        pick = 0;
        found = 1'b0;
        span = 0;
        for (i = 0; i + 1 < blk_count; i++) begin
            if (!found && blk_free[i] && (blk_bytes[i] > req + HDR || blk_bytes[i] == req)) begin
                pick = i;
                found = 1'b1;
            end
        end
        // last block only needs to be at least the request
        if (!found && blk_count > 0) begin
            if (blk_free[blk_count-1] && blk_bytes[blk_count-1] >= req) begin
                pick = blk_count - 1;
                found = 1'b1;
            end
        end
        grow = !found;
        if (grow) begin
            span = ((req + HDR) / PAGE + 1) * PAGE;
            sz = span - HDR;
        end else begin
            sz = blk_bytes[pick];
        end
        split = sz > req + HDR;
        lim = (limit_reg < HEAPSZ) ? limit_reg : HEAPSZ;
        if (grow && brk + span > lim) begin
            r.status = ST_LIMIT;
            return r;
        end
        need = int'(grow) + int'(split);
        if (blk_count + need > NBLK) begin
            r.status = ST_FULL;
            return r;
        end
        if (grow) begin
            pick = blk_count;
            blk_start[pick] = brk;
            blk_bytes[pick] = sz;
            blk_free[pick] = 1'b1;
            blk_count++;
            brk += span;
        end
        if (split) begin
            for (i = blk_count; i > pick + 1; i--) begin
                blk_start[i] = blk_start[i-1];
                blk_bytes[i] = blk_bytes[i-1];
                blk_free[i] = blk_free[i-1];
            end
            blk_start[pick+1] = blk_start[pick] + HDR + req;
            blk_bytes[pick+1] = sz - req - HDR;
            blk_free[pick+1] = 1'b1;
            blk_count++;
            blk_bytes[pick] = req;
        end
        blk_free[pick] = 1'b0;
        r.offset = OffW'(blk_start[pick] + HDR);
        r.gsize = SizeW'(blk_bytes[pick]);
        return r;
    endfunction

    // result side backpressure in random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 6) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        alloc_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d offset %0d size %0d",
                             m_status, m_payload_offset, m_granted_size);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_status !== exp_r.status || m_payload_offset !== exp_r.offset
                        || m_granted_size !== exp_r.gsize) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 exp_r.status, exp_r.offset, exp_r.gsize,
                                 m_status, m_payload_offset, m_granted_size);
                end
            end
        end
    end

    // one request transfer; valid stays up for back-to-back requests
    task automatic send_request(input logic [SizeW-1:0] req);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_request_size <= req;
        pending_results.push_back(allocate(req));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // heap_limit write, only with the block idle
    task automatic write_limit(input logic [SizeW-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        limit_reg = value;
        @(posedge aclk);
    endtask

    function automatic logic [SizeW-1:0] random_size();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return SizeW'($urandom_range(0, 200));
        else if (sel < 75) return SizeW'($urandom_range(0, 4200));
        else if (sel < 90) return SizeW'($urandom_range(4000, 40000));
        else return SizeW'($urandom);
    endfunction

    // limit of zero blocks all growth, then back to full size
    task automatic test_limit_extremes();
        write_limit('0);
        send_request(21'd0);
        send_request(21'd100);
        write_limit(21'd1048576);
    endtask

    // zero, exact fit of the last block, split, huge and all-ones requests
    task automatic test_directed();
        send_request(21'd0);
        send_request(21'd4000);
        send_request(21'd0);
        send_request(21'd4064);
        send_request(21'd5000);
        send_request(21'd1048576);
        send_request(21'h1FFFFF);
        send_request(21'h0AAAAA);
        send_request(21'h155555);
        send_request(21'd1);
        send_request(21'd31);
        send_request(21'd32);
        send_request(21'd33);
        send_request(21'd64);
        send_request(21'd8191);
        send_request(21'd4063);
        send_request(21'd4064);
        send_request(21'd100000);
    endtask

    // random sizes, run by the caller over several limit settings; the table fills along the way
    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) send_request(random_size());
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_limit_extremes();
        test_directed();
        write_limit(21'($urandom_range(0, 1048576)));
        test_random(200);
        write_limit(21'($urandom_range(200000, 1048576)));
        test_random(200);
        write_limit(21'd1048576);
        test_random(200);
        wait_idle();
        quiet = 1'b1;
        test_random(150);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
